// File: hdl/fhpd_pkg.sv
// Shared types and constants for the frame header and payload deframer.
`default_nettype none

package fhpd_pkg;

    localparam logic [7:0] HEADER_BYTES   = 8'd16;
    localparam logic [7:0] IDENT_BYTES    = 8'd8;
    localparam logic [7:0] SEQUENCE_BYTES = 8'd4;

    // One result of the parser, before the output register.
    typedef struct packed {
        logic        valid;
        logic        payload_valid;
        logic [7:0]  payload_byte;
        logic [7:0]  payload_index;
        logic        frame_done;
        logic [7:0]  command_code;
        logic [7:0]  total_length;
        logic [7:0]  device_kind;
        logic [63:0] device_ident;
        logic [31:0] sequence_number;
    } res_t;

endpackage

`default_nettype wire

// File: hdl/fhpd_parse.sv
// Frame parser: header capture state and the result for the current byte.
`default_nettype none

module fhpd_parse (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         step,
    input  wire logic [7:0]   rx_byte,
    input  wire logic [7:0]   expected_version,
    output fhpd_pkg::res_t    res
);
    import fhpd_pkg::*;

    localparam logic [2:0] PH_HUNT     = 3'd0;
    localparam logic [2:0] PH_COMMAND  = 3'd1;
    localparam logic [2:0] PH_LENGTH   = 3'd2;
    localparam logic [2:0] PH_KIND     = 3'd3;
    localparam logic [2:0] PH_IDENT    = 3'd4;
    localparam logic [2:0] PH_SEQUENCE = 3'd5;
    localparam logic [2:0] PH_PAYLOAD  = 3'd6;

    logic [2:0]  phase_reg,    phase_next;
    logic [7:0]  count_reg,    count_next;
    logic [7:0]  command_reg,  command_next;
    logic [7:0]  length_reg,   length_next;
    logic [7:0]  kind_reg,     kind_next;
    logic [63:0] ident_reg,    ident_next;
    logic [31:0] sequence_reg, sequence_next;

    logic [7:0]  count_inc;
    logic [7:0]  payload_count;
    logic        emit;
    logic        pay;
    logic        done;

    assign count_inc     = count_reg + 8'd1;
    assign payload_count = length_reg - HEADER_BYTES;

    always_comb
    begin
        phase_next    = phase_reg;
        count_next    = count_reg;
        command_next  = command_reg;
        length_next   = length_reg;
        kind_next     = kind_reg;
        ident_next    = ident_reg;
        sequence_next = sequence_reg;
        emit          = 1'b0;
        pay           = 1'b0;
        done          = 1'b0;
        unique case (phase_reg)
            PH_HUNT:
            begin
                if (rx_byte == expected_version)
                begin
                    count_next    = 8'd0;
                    ident_next    = '0;
                    sequence_next = '0;
                    phase_next    = PH_COMMAND;
                end
            end
            PH_COMMAND:
            begin
                command_next = rx_byte;
                phase_next   = PH_LENGTH;
            end
            PH_LENGTH:
            begin
                length_next = rx_byte;
                phase_next  = PH_KIND;
            end
            PH_KIND:
            begin
                kind_next  = rx_byte;
                count_next = 8'd0;
                phase_next = PH_IDENT;
            end
            PH_IDENT:
            begin
                ident_next = {ident_reg[55:0], rx_byte};
                count_next = count_inc;
                if (count_inc >= IDENT_BYTES)
                begin
                    count_next = 8'd0;
                    phase_next = PH_SEQUENCE;
                end
            end
            PH_SEQUENCE:
            begin
                sequence_next = {sequence_reg[23:0], rx_byte};
                count_next    = count_inc;
                if (count_inc >= SEQUENCE_BYTES)
                begin
                    count_next = 8'd0;
                    if (length_reg <= HEADER_BYTES)
                    begin
                        // Header-only frame ends on its last sequence byte.
                        phase_next = PH_HUNT;
                        emit       = 1'b1;
                        done       = 1'b1;
                    end
                    else
                    begin
                        phase_next = PH_PAYLOAD;
                    end
                end
            end
            PH_PAYLOAD:
            begin
                emit       = 1'b1;
                pay        = 1'b1;
                count_next = count_inc;
                if (count_inc >= payload_count)
                begin
                    done       = 1'b1;
                    count_next = 8'd0;
                    phase_next = PH_HUNT;
                end
            end
            default:
            begin
                phase_next = PH_HUNT;
                count_next = 8'd0;
            end
        endcase
    end

    // On a header-only frame, the sequence number of the finished frame includes the byte taken this step.
    always_comb
    begin
        res.valid           = emit;
        res.payload_valid   = pay;
        res.payload_byte    = pay ? rx_byte : 8'd0;
        res.payload_index   = pay ? count_reg : 8'd0;
        res.frame_done      = done;
        res.command_code    = done ? command_reg : 8'd0;
        res.total_length    = done ? length_reg : 8'd0;
        res.device_kind     = done ? kind_reg : 8'd0;
        res.device_ident    = done ? ident_reg : 64'd0;
        res.sequence_number = done ? sequence_next : 32'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_HUNT;
            count_reg    <= 8'd0;
            command_reg  <= 8'd0;
            length_reg   <= 8'd0;
            kind_reg     <= 8'd0;
            ident_reg    <= 64'd0;
            sequence_reg <= 32'd0;
        end
        else if (step)
        begin
            phase_reg    <= phase_next;
            count_reg    <= count_next;
            command_reg  <= command_next;
            length_reg   <= length_next;
            kind_reg     <= kind_next;
            ident_reg    <= ident_next;
            sequence_reg <= sequence_next;
        end
    end

endmodule

`default_nettype wire

// File: hdl/frame_header_payload_deframer.sv
// Top level of the frame header and payload deframer with its stream ports.
//
// The block takes one received byte per item and can accept a byte in every
// cycle while the output side does not stall. A byte passes an input register
// and then the parser, whose result is caught in an output register; a result
// waits there until the output side is ready. Header bytes give no result but
// the last one of a header-only frame; each payload byte gives one item, and
// the item that ends a frame has tlast set and carries all header fields. There
// is no clearing pass after reset. The version register resets to 1.
`default_nettype none

module frame_header_payload_deframer (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           cfg_wr_en,
    input  wire logic [7:0]     cfg_wr_data,     // expected_version
    input  wire logic           s_axis_tvalid,
    output      logic           s_axis_tready,
    input  wire logic [7:0]     s_axis_tdata,    // rx_byte
    output      logic           m_axis_tvalid,
    input  wire logic           m_axis_tready,
    // payload_byte, payload_index, command_code, total_length, device_kind,
    // device_ident, sequence_number
    output      logic [135:0]   m_axis_tdata,
    output      logic           m_axis_tuser,    // payload_valid
    output      logic           m_axis_tlast     // frame_done
);
    import fhpd_pkg::*;

    logic [7:0]   version_reg;
    logic         in_valid_reg;
    logic [7:0]   in_data_reg;
    logic         out_valid_reg;
    logic [135:0] out_data_reg;
    logic         out_user_reg;
    logic         out_last_reg;
    logic         step;
    res_t         res;

    // The held byte moves on whenever the output register is free or draining.
    assign step          = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || step;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            version_reg <= 8'd1;
        end
        else if (cfg_wr_en)
        begin
            version_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_data_reg <= s_axis_tdata;
        end
    end

    fhpd_parse u_parse (
        .clk              (clk),
        .rst_n            (rst_n),
        .step             (step),
        .rx_byte          (in_data_reg),
        .expected_version (version_reg),
        .res              (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (step)
        begin
            out_valid_reg <= res.valid;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step && res.valid)
        begin
            out_data_reg <= {res.sequence_number, res.device_ident, res.device_kind,
                             res.total_length, res.command_code, res.payload_index,
                             res.payload_byte};
            out_user_reg <= res.payload_valid;
            out_last_reg <= res.frame_done;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_user_reg;
    assign m_axis_tlast  = out_last_reg;

`ifndef NO_ASSERTIONS
    // Every result either carries a payload byte or ends a frame.
    a_result_kind: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tuser || m_axis_tlast))
        else $error("result with neither payload nor frame end");

    // Without a payload byte the payload fields read as zero.
    a_payload_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata[15:0] == 16'd0))
        else $error("payload fields set on a header-only result");

    // Header fields are shown only on the item that ends a frame.
    a_header_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tlast) |-> (m_axis_tdata[135:16] == 120'd0))
        else $error("header fields set before the frame end");

    // The last payload byte sits at length minus the header minus one.
    a_last_index: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tlast && m_axis_tuser)
            |-> (m_axis_tdata[15:8] == (m_axis_tdata[31:24] - HEADER_BYTES - 8'd1)))
        else $error("frame ended at the wrong payload index");

    // An end without a payload byte only comes on a frame whose length claims no payload.
    a_short_frame: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tlast && !m_axis_tuser)
            |-> (m_axis_tdata[31:24] <= HEADER_BYTES))
        else $error("header-only end on a frame with payload");
`endif

endmodule

`default_nettype wire

// File: verif/tb_frame_header_payload_deframer.sv
// Testbench for the frame header and payload deframer: directed frames, then random traffic.
`timescale 1ns / 100ps

module tb_frame_header_payload_deframer;

    import fhpd_pkg::*;

    localparam int CLK_PERIOD  = 8;
    localparam int QUIET_LIMIT = 2000;
    // Input register plus output register, with some margin.
    localparam int DRAIN_CYCLES = 4;

    localparam logic [2:0] HUNT         = 3'd0;
    localparam logic [2:0] GET_COMMAND  = 3'd1;
    localparam logic [2:0] GET_LENGTH   = 3'd2;
    localparam logic [2:0] GET_KIND     = 3'd3;
    localparam logic [2:0] GET_IDENT    = 3'd4;
    localparam logic [2:0] GET_SEQUENCE = 3'd5;
    localparam logic [2:0] GET_PAYLOAD  = 3'd6;

    typedef struct packed {
        logic        payload_valid;
        logic [7:0]  payload_byte;
        logic [7:0]  payload_index;
        logic        frame_done;
        logic [7:0]  command_code;
        logic [7:0]  total_length;
        logic [7:0]  device_kind;
        logic [63:0] device_ident;
        logic [31:0] sequence_number;
    } deframed_t;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         cfg_wr_en = 1'b0;
    logic [7:0]   cfg_wr_data = 8'd0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [7:0]   s_axis_tdata = 8'd0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [135:0] m_axis_tdata;
    logic         m_axis_tuser;
    logic         m_axis_tlast;

    frame_header_payload_deframer uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // Shadow of the parser state and its version register.
    logic [2:0]  sh_phase = HUNT;
    logic [7:0]  sh_count = 8'd0;
    logic [7:0]  sh_command = 8'd0;
    logic [7:0]  sh_length = 8'd0;
    logic [7:0]  sh_kind = 8'd0;
    logic [63:0] sh_ident = 64'd0;
    logic [31:0] sh_sequence = 32'd0;
    logic [7:0]  sh_version = 8'd1;

    deframed_t frames_expected[$];
    int        error_count = 0;
    int        send_gap_pct = 0;
    int        recv_stall_pct = 0;
    int        quiet_cycles = 0;

    initial
    begin
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // Work out what the parser yields for one accepted byte.
    task automatic deframe_byte(input logic [7:0] b);
        deframed_t   res;
        logic [7:0]  payload_count;
        logic        emit;
        res = '0;
        emit = 1'b0;
        case (sh_phase)
            HUNT:
            begin
                if (b == sh_version)
                begin
                    sh_count = 8'd0;
                    sh_ident = 64'd0;
                    sh_sequence = 32'd0;
                    sh_phase = GET_COMMAND;
                end
            end
            GET_COMMAND:
            begin
                sh_command = b;
                sh_phase = GET_LENGTH;
            end
            GET_LENGTH:
            begin
                sh_length = b;
                sh_phase = GET_KIND;
            end
            GET_KIND:
            begin
                sh_kind = b;
                sh_count = 8'd0;
                sh_phase = GET_IDENT;
            end
            GET_IDENT:
            begin
                sh_ident = {sh_ident[55:0], b};
                sh_count = sh_count + 8'd1;
                if (sh_count >= IDENT_BYTES)
                begin
                    sh_count = 8'd0;
                    sh_phase = GET_SEQUENCE;
                end
            end
            GET_SEQUENCE:
            begin
                sh_sequence = {sh_sequence[23:0], b};
                sh_count = sh_count + 8'd1;
                if (sh_count >= SEQUENCE_BYTES)
                begin
                    sh_count = 8'd0;
                    if (sh_length <= HEADER_BYTES)
                    begin
                        sh_phase = HUNT;
                        emit = 1'b1;
                        res.frame_done = 1'b1;
                    end
                    else
                    begin
                        sh_phase = GET_PAYLOAD;
                    end
                end
            end
            GET_PAYLOAD:
            begin
                payload_count = sh_length - HEADER_BYTES;
                emit = 1'b1;
                res.payload_valid = 1'b1;
                res.payload_byte = b;
                res.payload_index = sh_count;
                sh_count = sh_count + 8'd1;
                if (sh_count >= payload_count)
                begin
                    sh_count = 8'd0;
                    sh_phase = HUNT;
                    res.frame_done = 1'b1;
                end
            end
            default:
            begin
                sh_phase = HUNT;
                sh_count = 8'd0;
            end
        endcase
        if (res.frame_done)
        begin
            res.command_code = sh_command;
            res.total_length = sh_length;
            res.device_kind = sh_kind;
            res.device_ident = sh_ident;
            res.sequence_number = sh_sequence;
        end
        if (emit)
            frames_expected.push_back(res);
    endtask

    // Offers one byte, with random gaps before it, and waits for acceptance.
    task automatic send_byte(input logic [7:0] b);
        if ($urandom_range(99) < send_gap_pct)
        begin
            s_axis_tvalid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_gap_pct);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= b;
        do
            @(posedge clk);
        while (!s_axis_tready);
        deframe_byte(b);
    endtask

    // Sends a frame with random payload; a nonnegative cut truncates it to that many bytes.
    task automatic send_frame(input logic [7:0] ver, input logic [7:0] cmd,
                              input logic [7:0] len, input logic [7:0] kind,
                              input logic [63:0] ident, input logic [31:0] seq,
                              input int cut, output int sent);
        logic [7:0] frame_bytes[$];
        int         payload_count;
        frame_bytes = {ver, cmd, len, kind};
        for (int i = 7; i >= 0; i--)
            frame_bytes.push_back(ident[8 * i +: 8]);
        for (int i = 3; i >= 0; i--)
            frame_bytes.push_back(seq[8 * i +: 8]);
        payload_count = (len > HEADER_BYTES) ? int'(len) - 16 : 0;
        for (int i = 0; i < payload_count; i++)
            frame_bytes.push_back(8'($urandom));
        if (cut >= 0 && cut < frame_bytes.size())
            frame_bytes = frame_bytes[0:cut - 1];
        sent = frame_bytes.size();
        foreach (frame_bytes[i])
            send_byte(frame_bytes[i]);
    endtask

    // Holds off the sender until every pending result has come out.
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (frames_expected.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_version(input logic [7:0] v);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        sh_version = v;
    endtask

    task automatic test_hunt_and_header_only();
        int n;
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'h02);
        send_frame(8'h01, 8'hFF, 8'd16, 8'hFF, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF, -1, n);
        send_frame(8'h01, 8'h00, 8'd0, 8'h00, 64'd0, 32'd0, -1, n);
        wait_idle();
    endtask

    task automatic test_payload_frames();
        int n;
        // A single payload byte is both the first and the last one.
        send_frame(8'h01, 8'h3C, 8'd17, 8'h81, 64'h0123_4567_89AB_CDEF, 32'h8000_0001, -1, n);
        send_frame(8'h01, 8'hC3, 8'd19, 8'h7E, 64'hFEDC_BA98_7654_3210, 32'h7FFF_FFFE, -1, n);
        send_frame(8'h01, 8'h55, 8'd255, 8'hAA, 64'h8000_0000_0000_0001, 32'h1234_5678, -1, n);
        wait_idle();
    endtask

    // The version changes while a frame is half received; only later hunting sees it.
    task automatic test_version_change_mid_frame();
        logic [7:0] head[$];
        int         n;
        head = {8'h01, 8'h11, 8'd20, 8'h22, 8'h01, 8'h02, 8'h03, 8'h04, 8'h05};
        foreach (head[i])
            send_byte(head[i]);
        wait_idle();
        write_version(8'h5A);
        head = {8'h06, 8'h07, 8'h08, 8'hA1, 8'hA2, 8'hA3, 8'hA4,
                8'hD0, 8'hD1, 8'hD2, 8'hD3, 8'h01};
        foreach (head[i])
            send_byte(head[i]);
        send_frame(8'h5A, 8'h99, 8'd10, 8'h44, 64'h5A5A_5A5A_5A5A_5A5A, 32'hA5A5_A5A5, -1, n);
        wait_idle();
    endtask

    task automatic test_random_traffic(input int gap_pct, input int stall_pct,
                                       input logic [7:0] ver, input int byte_budget);
        int         sent;
        int         n;
        int         pick;
        int         cut;
        logic [7:0] len;
        send_gap_pct = gap_pct;
        recv_stall_pct = stall_pct;
        write_version(ver);
        sent = 0;
        while (sent < byte_budget)
        begin
            repeat ($urandom_range(3))
            begin
                send_byte(8'($urandom));
                sent++;
            end
            pick = $urandom_range(99);
            if (pick < 10)
                len = 8'($urandom_range(16));
            else if (pick < 97)
                len = 8'($urandom_range(48, 17));
            else
                len = 8'($urandom_range(255, 200));
            cut = ($urandom_range(99) < 10) ? int'($urandom_range(30, 1)) : -1;
            send_frame(ver, 8'($urandom), len, 8'($urandom), {$urandom, $urandom},
                       32'($urandom), cut, n);
            sent += n;
        end
        wait_idle();
    endtask

    function automatic void check_field(input string fname, input logic [63:0] want,
                                        input logic [63:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, fname, want, got);
            error_count++;
        end
    endfunction

    always @(posedge clk)
    begin
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge clk)
    begin
        deframed_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (frames_expected.size() == 0)
            begin
                $display("%0t: unexpected item, expected none, actual tdata %h tuser %b tlast %b",
                         $time, m_axis_tdata, m_axis_tuser, m_axis_tlast);
                error_count++;
            end
            else
            begin
                want = frames_expected.pop_front();
                check_field("payload_valid", 64'(want.payload_valid), 64'(m_axis_tuser));
                check_field("payload_byte", 64'(want.payload_byte), 64'(m_axis_tdata[7:0]));
                check_field("payload_index", 64'(want.payload_index),
                            64'(m_axis_tdata[15:8]));
                check_field("frame_done", 64'(want.frame_done), 64'(m_axis_tlast));
                check_field("command_code", 64'(want.command_code),
                            64'(m_axis_tdata[23:16]));
                check_field("total_length", 64'(want.total_length),
                            64'(m_axis_tdata[31:24]));
                check_field("device_kind", 64'(want.device_kind), 64'(m_axis_tdata[39:32]));
                check_field("device_ident", want.device_ident, m_axis_tdata[103:40]);
                check_field("sequence_number", 64'(want.sequence_number),
                            64'(m_axis_tdata[135:104]));
            end
        end
    end

    // Ends the run when neither side has moved an item for too long.
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("tb_frame_header_payload_deframer: done, errors");
            $finish;
        end
    end

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_hunt_and_header_only();
        test_payload_frames();
        test_version_change_mid_frame();
        test_random_traffic(0, 0, 8'h00, 380);
        test_random_traffic(46, 0, 8'hFF, 380);
        test_random_traffic(0, 46, 8'($urandom), 380);
        test_random_traffic(9, 9, 8'h01, 380);
        if (error_count == 0)
            $display("tb_frame_header_payload_deframer: done, clean");
        else
            $display("tb_frame_header_payload_deframer: done, errors");
        $finish;
    end

endmodule

// File: sim.f
hdl/fhpd_pkg.sv
hdl/fhpd_parse.sv
hdl/frame_header_payload_deframer.sv
verif/tb_frame_header_payload_deframer.sv
